FILE: src/mesab_pkg.sv
// ----------------------------------------------------------------------------
// Mask edge smoothing and alpha blend: shared package
// Register codes, field widths, reset values and the alpha class type used
// across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package mesab_pkg;

  // Field widths
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 12;
  localparam int COLOR_W        = 25;
  localparam int CHAN_W         = 8;
  localparam int SUM_W          = 2 * CHAN_W;
  localparam int TRANSP_BIT     = 24;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 25;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FG_COLOR     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BG_COLOR     = 2'd3;

  // Register reset values
  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd1;
  localparam logic [COLOR_W-1:0]        FG_COLOR_RESET     = 25'h0FF_FFFF;
  localparam logic [COLOR_W-1:0]        BG_COLOR_RESET     = 25'h000_0000;

  // Alpha classes: 0, 64, 128 and 255
  typedef enum logic [1:0] {
    ALPHA_ZERO,
    ALPHA_QUARTER,
    ALPHA_HALF,
    ALPHA_FULL
  } alpha_t;

endpackage

`default_nettype wire

FILE: src/mesab_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered under a read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module mesab_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/mesab_tap_cell.sv
// ----------------------------------------------------------------------------
// Window tap cell
// Holds one middle-row mask bit and hands it to the next cell on each slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mesab_tap_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic din,
  output logic q
);

  // Take the neighbour's bit when the window advances
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (shift) begin
      q <= din;
    end
  end

endmodule

`default_nettype wire

FILE: src/mesab_blend_lane.sv
// ----------------------------------------------------------------------------
// Blend lane
// Two-stage blend of one colour channel: weighted sum, then divide by 255.
// ----------------------------------------------------------------------------
`default_nettype none

module mesab_blend_lane (
  input  logic                          clk,
  input  logic                          en,
  input  mesab_pkg::alpha_t             alpha,
  input  logic [mesab_pkg::CHAN_W-1:0]  fg,
  input  logic [mesab_pkg::CHAN_W-1:0]  bg,
  output logic [mesab_pkg::CHAN_W-1:0]  chan
);
  import mesab_pkg::*;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W:0]   scaled;

  // Weighted sum fg*a + bg*(255-a), built from shifts since a is one of four values
  always_comb begin
    case (alpha)
      ALPHA_ZERO:    sum_next = {bg, 8'd0} - SUM_W'(bg);
      ALPHA_QUARTER: sum_next = SUM_W'({fg, 6'd0}) + SUM_W'({bg, 7'd0})
                              + SUM_W'({bg, 6'd0}) - SUM_W'(bg);
      ALPHA_HALF:    sum_next = SUM_W'({fg, 7'd0}) + SUM_W'({bg, 7'd0}) - SUM_W'(bg);
      ALPHA_FULL:    sum_next = {fg, 8'd0} - SUM_W'(fg);
      default:       sum_next = '0;
    endcase
  end

  // Divide by 255: exact for sums up to 255*255, the largest weighted sum
  assign scaled = (SUM_W+1)'(sum) + (SUM_W+1)'(sum[SUM_W-1:CHAN_W]) + (SUM_W+1)'(1);

  // Advance both stages together with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= sum_next;
      chan <= scaled[SUM_W-1:CHAN_W];
    end
  end

endmodule

`default_nettype wire

FILE: src/mask_edge_smooth_alpha_blend.sv
// ----------------------------------------------------------------------------
// Mask edge smoothing and alpha blend
// Turns a one-bit coverage mask in raster order into blended colour pixels.
// ----------------------------------------------------------------------------
// The block takes one item per clock and gives one result per clock once the
// lag of frame_width+1 pixels is filled; drain items (tuser high) flush the
// pending pixels. A result passes the stage A to B registers, the stage B
// registers, the blend sum and the output register. The line stores sit in
// one RAM with one read and one write per pixel, and that port pair sets the
// one-pixel-per-cycle rate. After reset a clearing pass zeroes all MAX_WIDTH
// line store entries; no item is accepted meanwhile (configuration writes are
// still taken). A stall on the output side holds the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mask_edge_smooth_alpha_blend #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input pixel stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] coverage_on, [7:1] zero
  input  logic                              s_tuser,   // [0] operation
  // Output pixel stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [23:0]                       m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                              m_tuser,   // [0] transparent
  output logic                              m_tlast,   // last_pixel
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mesab_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mesab_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mesab_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WC_A   = $clog2(MAX_WIDTH + 1);
  localparam int HC_A   = $clog2(MAX_HEIGHT + 1);
  localparam int WC     = ((WC_A > FRAME_WIDTH_W) ? WC_A : FRAME_WIDTH_W) + 1;
  localparam int HC     = ((HC_A > FRAME_HEIGHT_W) ? HC_A : FRAME_HEIGHT_W) + 1;
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic [COLOR_W-1:0]        fg_color;
  logic [COLOR_W-1:0]        bg_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      fg_color     <= FG_COLOR_RESET;
      bg_color     <= BG_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        CFG_FG_COLOR:     fg_color     <= cfg_data[COLOR_W-1:0];
        CFG_BG_COLOR:     bg_color     <= cfg_data[COLOR_W-1:0];
        default:          ;
      endcase
    end
  end

  // Clamp the frame size to 1..MAX
  logic [WC-1:0] eff_w;
  logic [HC-1:0] eff_h;
  logic [WC-1:0] lag;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WC'(1);
    end else if (WC'(frame_width) > WC'(MAX_WIDTH)) begin
      eff_w = WC'(MAX_WIDTH);
    end else begin
      eff_w = WC'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = HC'(1);
    end else if (HC'(frame_height) > HC'(MAX_HEIGHT)) begin
      eff_h = HC'(MAX_HEIGHT);
    end else begin
      eff_h = HC'(frame_height);
    end
    lag = eff_w + WC'(1);
  end

  // --------------------------------------------------------------------------
  // Pipeline control and clearing pass
  // --------------------------------------------------------------------------
  logic             en;
  logic             acc;
  logic             clr_active;
  logic [COL_W-1:0] clr_addr;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !clr_active;
  assign acc      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: slot decision, column and output position
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]  in_column;
  logic [COL_W-1:0]  in_column_next;
  logic [PEND_W-1:0] pending;
  logic [PEND_W-1:0] pending_next;
  logic [COL_W-1:0]  out_column;
  logic [COL_W-1:0]  out_column_next;
  logic [ROW_W-1:0]  out_row;
  logic [ROW_W-1:0]  out_row_next;

  logic             drain;
  logic             slot;
  logic             emit;
  logic             slot_bit;
  logic [COL_W-1:0] col_in;
  logic [COL_W-1:0] col_out;
  logic [ROW_W-1:0] row_out;
  logic             col_out_last;
  logic             row_out_last;
  logic             border;
  logic             last;

  always_comb begin
    drain    = s_tuser;
    slot     = acc && !(drain && pending == '0);
    emit     = drain || (WC'(pending) >= lag);
    slot_bit = drain ? 1'b0 : s_tdata[0];

    // Write column, wrapped if the width shrank
    col_in = (WC'(in_column) >= eff_w) ? '0 : in_column;
    in_column_next = (WC'(col_in) + WC'(1) >= eff_w) ? '0 : col_in + COL_W'(1);

    // Fill, hold or drain the lag
    if (drain) begin
      pending_next = pending - PEND_W'(1);
    end else if (!emit) begin
      pending_next = pending + PEND_W'(1);
    end else begin
      pending_next = pending;
    end

    // Position of the pixel being emitted
    col_out      = (WC'(out_column) >= eff_w) ? '0 : out_column;
    row_out      = (HC'(out_row) >= eff_h) ? '0 : out_row;
    col_out_last = WC'(col_out) + WC'(1) >= eff_w;
    row_out_last = HC'(row_out) + HC'(1) >= eff_h;
    border       = (row_out == '0) || row_out_last || (col_out == '0) || col_out_last;
    last         = row_out_last && col_out_last;

    if (col_out_last) begin
      out_column_next = '0;
      out_row_next    = row_out_last ? '0 : row_out + ROW_W'(1);
    end else begin
      out_column_next = col_out + COL_W'(1);
      out_row_next    = row_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      pending    <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (slot) begin
      in_column <= in_column_next;
      pending   <= pending_next;
      if (emit) begin
        out_column <= out_column_next;
        out_row    <= out_row_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line stores: bit 1 upper row, bit 0 middle row
  // --------------------------------------------------------------------------
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_bit;
  logic [COL_W-1:0] s1_col;
  logic             s1_border;
  logic             s1_last;
  logic             fwd_hit;
  logic [1:0]       fwd_data;

  logic             ram_wr_en;
  logic [COL_W-1:0] ram_wr_addr;
  logic [1:0]       ram_wr_data;
  logic [1:0]       ram_rd_data;
  logic [1:0]       line_bits;
  logic             up_row_bit;
  logic             mid_row_bit;

  assign line_bits   = fwd_hit ? fwd_data : ram_rd_data;
  assign up_row_bit  = line_bits[1];
  assign mid_row_bit = line_bits[0];

  // Clearing pass owns the write port until it ends
  always_comb begin
    if (clr_active) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = s1_valid && en;
      ram_wr_addr = s1_col;
      ram_wr_data = {mid_row_bit, s1_bit};
    end
  end

  mesab_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (slot),
    .rd_addr (col_in),
    .rd_data (ram_rd_data)
  );

  // Stage A to B registers; forward a write to the same column (width of one)
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_emit   <= emit;
      s1_bit    <= slot_bit;
      s1_col    <= col_in;
      s1_border <= border;
      s1_last   <= last;
      fwd_hit   <= s1_valid && (s1_col == col_in);
      fwd_data  <= {mid_row_bit, s1_bit};
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: neighbourhood window and alpha class
  // --------------------------------------------------------------------------
  logic       win_shift;
  logic [2:0] win;
  logic       prev_upper;
  logic       prev_input;

  assign win_shift = s1_valid && en;

  // Row of tap cells: win[0] newest, win[2] oldest
  mesab_tap_cell u_tap0 (
    .clk (clk), .rst (rst), .shift (win_shift), .din (mid_row_bit), .q (win[0])
  );
  mesab_tap_cell u_tap1 (
    .clk (clk), .rst (rst), .shift (win_shift), .din (win[0]), .q (win[1])
  );
  mesab_tap_cell u_tap2 (
    .clk (clk), .rst (rst), .shift (win_shift), .din (win[1]), .q (win[2])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_upper <= 1'b0;
      prev_input <= 1'b0;
    end else if (win_shift) begin
      prev_upper <= up_row_bit;
      prev_input <= s1_bit;
    end
  end

  alpha_t     alpha_cls;
  logic [2:0] ink_count;
  logic       transp;

  // Centre from win[0], left from win[1], right from the fresh middle bit
  always_comb begin
    ink_count = 3'(prev_upper) + 3'(win[1]) + 3'(mid_row_bit) + 3'(prev_input);
    if (win[0]) begin
      alpha_cls = ALPHA_FULL;
    end else if (s1_border) begin
      alpha_cls = ALPHA_ZERO;
    end else begin
      case (ink_count)
        3'd0:    alpha_cls = ALPHA_ZERO;
        3'd1:    alpha_cls = ALPHA_QUARTER;
        default: alpha_cls = ALPHA_HALF;
      endcase
    end
    case (alpha_cls)
      ALPHA_ZERO: transp = bg_color[TRANSP_BIT];
      ALPHA_FULL: transp = fg_color[TRANSP_BIT];
      default:    transp = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stages C and D: blend lanes and output register
  // --------------------------------------------------------------------------
  logic   s2_valid;
  alpha_t s2_alpha;
  logic   s2_transp;
  logic   s2_last;
  logic   s3_valid;
  logic   s3_transp;
  logic   s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_emit;
      s3_valid <= s2_valid;
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_alpha  <= alpha_cls;
      s2_transp <= transp;
      s2_last   <= s1_last;
      s3_transp <= s2_transp;
      s3_last   <= s2_last;
      m_tuser   <= s3_transp;
      m_tlast   <= s3_last;
    end
  end

  mesab_blend_lane u_lane_red (
    .clk   (clk),
    .en    (en),
    .alpha (s2_alpha),
    .fg    (fg_color[23:16]),
    .bg    (bg_color[23:16]),
    .chan  (m_tdata[7:0])
  );

  mesab_blend_lane u_lane_green (
    .clk   (clk),
    .en    (en),
    .alpha (s2_alpha),
    .fg    (fg_color[15:8]),
    .bg    (bg_color[15:8]),
    .chan  (m_tdata[15:8])
  );

  mesab_blend_lane u_lane_blue (
    .clk   (clk),
    .en    (en),
    .alpha (s2_alpha),
    .fg    (fg_color[7:0]),
    .bg    (bg_color[7:0]),
    .chan  (m_tdata[23:16])
  );

endmodule

`default_nettype wire

FILE: src/mesab_checker.sv
// ----------------------------------------------------------------------------
// Mask edge smoothing and alpha blend: port checker
// Watches the top level's ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module mesab_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [7:0]                        s_tdata,
  input logic                              s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [23:0]                       m_tdata,
  input logic                              m_tuser,
  input logic                              m_tlast,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [mesab_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [mesab_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // No result straight out of reset
  a_no_out_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // Line stores are being cleared after reset, so no pixel is taken
  a_no_accept_while_clearing: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("pixel taken during the clearing pass");

  // A stalled result holds the input side too
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while the output is stalled");

  // A stalled result keeps its payload
  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind mask_edge_smooth_alpha_blend mesab_checker u_checker (.*);

`default_nettype wire
